/* rtl/vbf_pkg.sv */
// ----------------------------------------------------------------------------
// vbf_pkg: shared types and constants for the variable width bit FIFO
// Field widths, status and opcode codes, command item and back-end states.
// ----------------------------------------------------------------------------
package vbf_pkg;

	// default sizing
	localparam int QUEUE_DEPTH_DEF = 256;
	localparam int MAX_WIDTH_DEF   = 24;

	// fixed field widths
	localparam int WIDTH_W  = 5;
	localparam int BITS_W   = 24;
	localparam int STATUS_W = 2;
	localparam int HELD_W   = 12;

	// byte handling
	localparam int        BYTE_BITS = 8;
	localparam logic [7:0] BYTE_MASK = 8'hff;

	// opcodes
	localparam logic OP_PUT = 1'b0;
	localparam logic OP_GET = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

	// command queue between front and back
	localparam int CMDQ_DEPTH = 2;

	// classified command item
	typedef struct packed {
		logic                op;
		logic [WIDTH_W-1:0]  width;
		logic [BITS_W-1:0]   bits;
	} cmd_t;

	// back-end sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_PUT,
		S_GET,
		S_MERGE,
		S_EXTRACT,
		S_DONE
	} back_state_t;

endpackage

/* rtl/vbf_ram.sv */
// ----------------------------------------------------------------------------
// vbf_ram: generic single-port RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
module vbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

/* rtl/vbf_front.sv */
// ----------------------------------------------------------------------------
// vbf_front: input stage of the bit FIFO
// Accepts items, saturates the width and masks the put value.
// ----------------------------------------------------------------------------
module vbf_front #(
	parameter int MAX_WIDTH = vbf_pkg::MAX_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       opcode,
	input  logic [vbf_pkg::BITS_W-1:0] bits,
	input  logic [vbf_pkg::WIDTH_W-1:0] width,
	output logic                       push,
	output vbf_pkg::cmd_t              cmd,
	input  logic                       q_full
);

	import vbf_pkg::*;

	logic               valid_s1;
	cmd_t               cmd_s1;
	logic [WIDTH_W-1:0] w_sat;
	logic [BITS_W:0]    mask_p1;
	logic               advance;

	// width saturation and value mask
	always_comb begin
		if (width > WIDTH_W'(MAX_WIDTH)) begin
			w_sat = WIDTH_W'(MAX_WIDTH);
		end else begin
			w_sat = width;
		end
		mask_p1 = (BITS_W + 1)'(1) << w_sat;
	end

	// stage advances when empty or when the queue takes the item
	assign push     = valid_s1 && !q_full;
	assign advance  = !valid_s1 || !q_full;
	assign in_stall = !advance;
	assign cmd      = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			cmd_s1.op    <= opcode;
			cmd_s1.width <= w_sat;
			cmd_s1.bits  <= bits & BITS_W'(mask_p1 - 1'b1);
		end
	end

endmodule

/* rtl/vbf_cmd_queue.sv */
// ----------------------------------------------------------------------------
// vbf_cmd_queue: short command queue between front and back
// Two entries, so each side can stall on its own.
// ----------------------------------------------------------------------------
module vbf_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  vbf_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output vbf_pkg::cmd_t pop_cmd
);

	import vbf_pkg::*;

	localparam int PW = $clog2(CMDQ_DEPTH);

	cmd_t              entry_q [CMDQ_DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [PW:0]       count_q;

	assign full    = (count_q == (PW + 1)'(CMDQ_DEPTH));
	assign valid   = (count_q != '0);
	assign pop_cmd = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

/* rtl/vbf_back.sv */
// ----------------------------------------------------------------------------
// vbf_back: execution sequencer of the bit FIFO
// Runs puts and gets against the byte store and holds the result register.
// ----------------------------------------------------------------------------
module vbf_back #(
	parameter int QUEUE_DEPTH = vbf_pkg::QUEUE_DEPTH_DEF,
	parameter int MAX_WIDTH   = vbf_pkg::MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  vbf_pkg::cmd_t                q_cmd,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [vbf_pkg::BITS_W-1:0]   data,
	output logic [vbf_pkg::STATUS_W-1:0] status,
	output logic [vbf_pkg::HELD_W-1:0]   bits_held
);

	import vbf_pkg::*;

	localparam int AW    = $clog2(QUEUE_DEPTH);
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int ACC_W = MAX_WIDTH + 7;
	localparam int CNT_W = $clog2(ACC_W + 1);
	localparam int NB_W  = $clog2((MAX_WIDTH + 7) / 8 + 1);
	localparam int HW    = CW + 4;

	back_state_t state_q, state_d;

	// architectural state
	logic [AW-1:0]   head_q, tail_q;
	logic [CW-1:0]   count_q;
	logic [6:0]      in_bits_q, out_bits_q;
	logic [2:0]      in_cnt_q, out_cnt_q;

	// working registers
	logic [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] w_q;
	logic [NB_W-1:0]  rd_left_q;
	logic             rd_pend_q;
	logic [BITS_W-1:0]   res_data_q;
	logic [STATUS_W-1:0] res_status_q;
	logic             out_valid_q;
	logic [BITS_W-1:0]   data_q;
	logic [STATUS_W-1:0] status_q;
	logic [HELD_W-1:0]   held_out_q;

	// RAM port
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;

	// decode helpers
	logic [CNT_W-1:0] w_c;
	logic [HW-1:0]    held;
	logic [CNT_W-1:0] cnt_put;
	logic [CW:0]      put_bytes;
	logic             put_ovf;
	logic             get_under;
	logic [CNT_W:0]   nb_full;
	logic [NB_W-1:0]  nb_need;
	logic [NB_W-1:0]  nb_rd;
	logic             rd_issue;
	logic             load;
	logic [CNT_W-1:0] rem;
	logic [ACC_W:0]   w_mask_p1;
	logic [ACC_W:0]   rem_mask_p1;
	logic [ACC_W-1:0] put_acc;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
		if (idx == AW'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return idx + 1'b1;
	endfunction

	function automatic logic [6:0] low7(input logic [2:0] n);
		logic [7:0] p;
		p = 8'd1 << n;
		return 7'(p - 1'b1);
	endfunction

	vbf_ram #(
		.WIDTH(8),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// classification of the command at the queue head
	always_comb begin
		w_c       = CNT_W'(q_cmd.width);
		held      = HW'(out_cnt_q) + HW'({count_q, 3'b000}) + HW'(in_cnt_q);
		cnt_put   = CNT_W'(in_cnt_q) + w_c;
		put_bytes = (CW + 1)'(cnt_put >> 3);
		put_ovf   = ((CW + 1)'(count_q) + put_bytes) > (CW + 1)'(QUEUE_DEPTH);
		get_under = held < HW'(q_cmd.width);
		put_acc   = (ACC_W'(in_bits_q) << w_c) | ACC_W'(q_cmd.bits);
		nb_full   = (CNT_W + 1)'(w_c - CNT_W'(out_cnt_q)) + (CNT_W + 1)'(7);
		nb_need   = NB_W'(nb_full >> 3);
		if (CNT_W'(out_cnt_q) >= w_c) begin
			nb_rd = '0;
		end else if (CW'(nb_need) > count_q) begin
			nb_rd = NB_W'(count_q);
		end else begin
			nb_rd = nb_need;
		end
	end

	// extraction helpers
	always_comb begin
		rem         = cnt_q - w_q;
		w_mask_p1   = (ACC_W + 1)'(1) << w_q;
		rem_mask_p1 = (ACC_W + 1)'(1) << rem;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					if (q_cmd.op == OP_PUT) begin
						state_d = put_ovf ? S_DONE : S_PUT;
					end else if (q_cmd.width == '0 || get_under) begin
						state_d = S_DONE;
					end else begin
						state_d = S_GET;
					end
				end
			end
			S_PUT: begin
				if (cnt_q < CNT_W'(BYTE_BITS)) begin
					state_d = S_DONE;
				end
			end
			S_GET: begin
				if (rd_left_q == '0 && !rd_pend_q) begin
					state_d = S_MERGE;
				end
			end
			S_MERGE:   state_d = S_EXTRACT;
			S_EXTRACT: state_d = S_DONE;
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = S_IDLE;
				end
			end
			default:   state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop       = 1'b0;
		load      = 1'b0;
		ram_we    = 1'b0;
		rd_issue  = 1'b0;
		ram_addr  = head_q;
		ram_wdata = 8'(acc_q >> (cnt_q - CNT_W'(BYTE_BITS))) & BYTE_MASK;
		case (state_q)
			S_IDLE:  pop = q_valid;
			S_PUT: begin
				ram_addr = tail_q;
				ram_we   = (cnt_q >= CNT_W'(BYTE_BITS));
			end
			S_GET:   rd_issue = (rd_left_q != '0);
			S_DONE:  load = !out_valid_q || !out_stall;
			default: pop = 1'b0;
		endcase
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			in_bits_q   <= '0;
			in_cnt_q    <= '0;
			out_bits_q  <= '0;
			out_cnt_q   <= '0;
			rd_left_q   <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= load || (out_valid_q && out_stall);
			case (state_q)
				S_IDLE: begin
					rd_left_q <= nb_rd;
					rd_pend_q <= 1'b0;
				end
				S_PUT: begin
					if (ram_we) begin
						tail_q  <= wrap_inc(tail_q);
						count_q <= count_q + 1'b1;
					end else begin
						in_bits_q <= 7'(acc_q) & low7(cnt_q[2:0]);
						in_cnt_q  <= cnt_q[2:0];
					end
				end
				S_GET: begin
					rd_pend_q <= rd_issue;
					if (rd_issue) begin
						head_q    <= wrap_inc(head_q);
						count_q   <= count_q - 1'b1;
						rd_left_q <= rd_left_q - 1'b1;
					end
				end
				S_MERGE: begin
					if (cnt_q < w_q) begin
						in_bits_q <= '0;
						in_cnt_q  <= '0;
					end
				end
				S_EXTRACT: begin
					out_bits_q <= 7'(acc_q & ACC_W'(rem_mask_p1 - 1'b1));
					out_cnt_q  <= rem[2:0];
				end
				default: rd_pend_q <= 1'b0;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				res_data_q <= '0;
				w_q        <= w_c;
				if (q_cmd.op == OP_PUT) begin
					res_status_q <= put_ovf ? ST_OVERFLOW : ST_OK;
					acc_q        <= put_acc;
					cnt_q        <= cnt_put;
				end else begin
					res_status_q <= (q_cmd.width != '0 && get_under) ? ST_UNDERFLOW : ST_OK;
					acc_q        <= ACC_W'(out_bits_q);
					cnt_q        <= CNT_W'(out_cnt_q);
				end
			end
			S_PUT: begin
				if (ram_we) begin
					cnt_q <= cnt_q - CNT_W'(BYTE_BITS);
				end
			end
			S_GET: begin
				if (rd_pend_q) begin
					acc_q <= (acc_q << BYTE_BITS) | ACC_W'(ram_rdata);
					cnt_q <= cnt_q + CNT_W'(BYTE_BITS);
				end
			end
			S_MERGE: begin
				// still short: take all pending input bits
				if (cnt_q < w_q) begin
					acc_q <= (acc_q << in_cnt_q) | ACC_W'(in_bits_q);
					cnt_q <= cnt_q + CNT_W'(in_cnt_q);
				end
			end
			S_EXTRACT: begin
				res_data_q <= BITS_W'((acc_q >> rem) & ACC_W'(w_mask_p1 - 1'b1));
			end
			S_DONE: begin
				if (load) begin
					data_q     <= res_data_q;
					status_q   <= res_status_q;
					held_out_q <= HELD_W'(held);
				end
			end
			default: cnt_q <= cnt_q;
		endcase
	end

	assign out_valid = out_valid_q;
	assign data      = data_q;
	assign status    = status_q;
	assign bits_held = held_out_q;

endmodule

/* rtl/variable_width_bit_fifo.sv */
// Items pass the front register and the queue. From the queue head, a put runs S_IDLE,
// S_PUT (one byte written per completed byte) and S_DONE; a get runs S_IDLE, S_GET
// (reads the queued bytes it needs), S_MERGE, S_EXTRACT and S_DONE; an overflowing put
// or a zero-width or underflowing get skips to S_DONE, where a stalled result waits.
// One item is executed at a time, bound by the single-port byte memory.
// Reset (arst_n low) empties the FIFO and both bit accumulators at once.
// ----------------------------------------------------------------------------
// variable_width_bit_fifo: bit FIFO with variable-width put and get
// Front stage, two-entry command queue, and a back-end sequencer on a byte RAM.
// ----------------------------------------------------------------------------
module variable_width_bit_fifo #(
	parameter int QUEUE_DEPTH = vbf_pkg::QUEUE_DEPTH_DEF,
	parameter int MAX_WIDTH   = vbf_pkg::MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         opcode,
	input  logic [vbf_pkg::BITS_W-1:0]   bits,
	input  logic [vbf_pkg::WIDTH_W-1:0]  width,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [vbf_pkg::BITS_W-1:0]   data,
	output logic [vbf_pkg::STATUS_W-1:0] status,
	output logic [vbf_pkg::HELD_W-1:0]   bits_held
);

	import vbf_pkg::*;

	cmd_t front_cmd;
	cmd_t q_cmd;
	logic front_push;
	logic q_full;
	logic q_valid;
	logic q_pop;

	vbf_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode  (opcode),
		.bits    (bits),
		.width   (width),
		.push    (front_push),
		.cmd     (front_cmd),
		.q_full  (q_full)
	);

	vbf_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (front_push),
		.push_cmd(front_cmd),
		.full    (q_full),
		.pop     (q_pop),
		.valid   (q_valid),
		.pop_cmd (q_cmd)
	);

	vbf_back #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.MAX_WIDTH  (MAX_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.pop      (q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data     (data),
		.status   (status),
		.bits_held(bits_held)
	);

endmodule

/* rtl/vbf_checker.sv */
// ----------------------------------------------------------------------------
// vbf_checker: port-level checks for the bit FIFO
// Result channel behavior over time, bound to the top level.
// ----------------------------------------------------------------------------
module vbf_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [vbf_pkg::BITS_W-1:0]   data,
	input logic [vbf_pkg::STATUS_W-1:0] status,
	input logic [vbf_pkg::HELD_W-1:0]   bits_held
);

	import vbf_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data) && $stable(status)
			&& $stable(bits_held))
		else $error("result changed while stalled");

	// only defined status codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_UNDERFLOW || status == ST_OVERFLOW))
		else $error("undefined status code");

	// a failed get returns no data
	a_under_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_UNDERFLOW |-> data == '0)
		else $error("underflow with nonzero data");

	// a failed put returns no data
	a_over_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OVERFLOW |-> data == '0)
		else $error("overflow with nonzero data");

endmodule

bind variable_width_bit_fifo vbf_checker u_vbf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.data     (data),
	.status   (status),
	.bits_held(bits_held)
);
